@@ design/assert_macros.svh @@
// Assertion macros shared by the RTL of the weight-limited FIFO.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ design/wlf_pkg.sv @@
// Types and constants of the weight-limited FIFO.
package wlf_pkg;

    localparam int COUNT_W  = 7;
    localparam int WEIGHT_W = 16;
    localparam int TOTAL_W  = 32;

    // Operation codes
    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_COUNT_FULL  = 2'd1;
    localparam logic [1:0] ST_WEIGHT_FULL = 2'd2;
    localparam logic [1:0] ST_EMPTY       = 2'd3;

    // Configuration register indexes
    localparam logic REG_COUNT_LIMIT  = 1'b0;
    localparam logic REG_WEIGHT_LIMIT = 1'b1;

    typedef struct packed {
        logic [63:0]         time_stamp;
        logic [31:0]         producer_id;
        logic [31:0]         order_number;
        logic [WEIGHT_W-1:0] item_weight;
    } entry_t;

    // Shared control broadcast to every cell of the chain
    typedef struct packed {
        logic               load;   // successful push this cycle
        logic               shift;  // successful pop this cycle
        logic [COUNT_W-1:0] fill;   // entries held before the operation
    } cell_ctrl_t;

endpackage

@@ design/wlf_cell.sv @@
// One storage cell of the FIFO chain: load a pushed entry or take the neighbor's.
module wlf_cell #(
    parameter int INDEX = 0
) (
    input  logic                aclk,
    input  wlf_pkg::cell_ctrl_t ctrl,
    input  wlf_pkg::entry_t     push_entry,
    input  wlf_pkg::entry_t     neighbor_entry,
    output wlf_pkg::entry_t     entry
);
    import wlf_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    logic   load_here;

    // The tail cell is the one whose position equals the fill level
    assign load_here = ctrl.load && (ctrl.fill == COUNT_W'(INDEX));

    always_comb begin
        entry_next = entry_reg;
        if (load_here) begin
            entry_next = push_entry;
        end else if (ctrl.shift) begin
            entry_next = neighbor_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

@@ design/weight_limited_fifo.sv @@
// Weight-limited FIFO top level: control, limits, result register and the cell chain.
// The result of each input transfer is registered and appears on the m_ side in the cycle after the transfer.
// One operation per cycle; the only stall is a held result with m_tready low.
// Storage is a chain of min(DEPTH, 127) cells; cell 0 is always the oldest entry.
// Reset (aresetn low, synchronous) empties the queue, zeroes the weight total and sets
// count_limit to 64 and weight_limit to all ones; stored entries are not cleared.
module weight_limited_fifo #(
    parameter int DEPTH = 64
) (
    input  logic         aclk,
    input  logic         aresetn,

    // Input items
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: operation[1:0], item_weight[17:2], order_number[49:18],
    //        producer_id[81:50], time_stamp[145:82], zero fill[151:146]
    input  logic [151:0] s_tdata,

    // Result items
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: status[1:0], out_weight[17:2], out_order[49:18], out_producer[81:50],
    //        out_time[145:82], entry_count[152:146], free_slots[159:153],
    //        free_weight[191:160]
    output logic [191:0] m_tdata,

    // Configuration writes
    input  logic         cfg_wr_en,
    input  logic         cfg_addr,
    input  logic [31:0]  cfg_wr_data
);
    import wlf_pkg::*;

    // count_limit never exceeds 127, so no more cells than that can ever fill
    localparam int CELL_MAX = (1 << COUNT_W) - 1;
    localparam int CELLS    = (DEPTH < CELL_MAX) ? DEPTH : CELL_MAX;
    localparam logic [COUNT_W-1:0] CELLS_L = COUNT_W'(CELLS);

    // Architectural state
    logic [COUNT_W-1:0] held_count_reg,   held_count_next;
    logic [TOTAL_W-1:0] total_weight_reg, total_weight_next;
    logic [COUNT_W-1:0] count_limit_reg;
    logic [TOTAL_W-1:0] weight_limit_reg;

    // Result register
    logic               out_valid_reg,  out_valid_next;
    logic [191:0]       out_data_reg,   out_data_next;

    // Input decode
    logic [1:0]         in_op;
    entry_t             in_entry;
    logic               in_xfer;

    logic               count_full;
    logic               weight_full;
    logic               push_ok;
    logic               pop_ok;
    logic [TOTAL_W:0]   weight_sum;
    logic [1:0]         status;
    entry_t             pop_entry;
    logic [COUNT_W-1:0] free_slots;
    logic [TOTAL_W-1:0] free_weight;

    cell_ctrl_t         cell_ctrl;
    entry_t             cell_entry [CELLS];

    assign in_op    = s_tdata[1:0];
    assign in_entry = s_tdata[145:2];

    // Accept while the result register is empty or being drained this cycle
    assign s_tready = !out_valid_reg || m_tready;
    assign in_xfer  = s_tvalid && s_tready;

    // Push checks: count first, then the running weight total (one bit wider)
    assign count_full  = (held_count_reg >= count_limit_reg) || (held_count_reg >= CELLS_L);
    assign weight_sum  = {1'b0, total_weight_reg} + (TOTAL_W + 1)'(in_entry.item_weight);
    assign weight_full = weight_sum > {1'b0, weight_limit_reg};

    assign push_ok = (in_op == OP_PUSH) && !count_full && !weight_full;
    assign pop_ok  = (in_op == OP_POP) && (held_count_reg != '0);

    always_comb begin
        held_count_next   = held_count_reg;
        total_weight_next = total_weight_reg;
        status            = ST_OK;
        pop_entry         = '0;
        case (in_op)
            OP_PUSH: begin
                if (count_full) begin
                    status = ST_COUNT_FULL;
                end else if (weight_full) begin
                    status = ST_WEIGHT_FULL;
                end else begin
                    held_count_next   = held_count_reg + COUNT_W'(1);
                    total_weight_next = weight_sum[TOTAL_W-1:0];
                end
            end
            OP_POP: begin
                if (!pop_ok) begin
                    status = ST_EMPTY;
                end else begin
                    // Head of the chain is the oldest entry
                    pop_entry       = cell_entry[0];
                    held_count_next = held_count_reg - COUNT_W'(1);
                    if (total_weight_reg >= TOTAL_W'(cell_entry[0].item_weight)) begin
                        total_weight_next = total_weight_reg
                                          - TOTAL_W'(cell_entry[0].item_weight);
                    end else begin
                        total_weight_next = '0;
                    end
                end
            end
            OP_CLEAR: begin
                // Drop all entries; cell contents stay but are no longer counted
                held_count_next   = '0;
                total_weight_next = '0;
            end
            default: begin
                // Unused code: no state change, status ok
            end
        endcase
    end

    // Free amounts after the operation, saturated at zero
    assign free_slots  = (count_limit_reg > held_count_next)
                       ? count_limit_reg - held_count_next : '0;
    assign free_weight = (weight_limit_reg > total_weight_next)
                       ? weight_limit_reg - total_weight_next : '0;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (in_xfer) begin
            out_valid_next = 1'b1;
            out_data_next  = {free_weight, free_slots, held_count_next, pop_entry, status};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_count_reg   <= '0;
            total_weight_reg <= '0;
            count_limit_reg  <= COUNT_W'(64);
            weight_limit_reg <= '1;
            out_valid_reg    <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (in_xfer) begin
                held_count_reg   <= held_count_next;
                total_weight_reg <= total_weight_next;
            end
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_COUNT_LIMIT:  count_limit_reg  <= cfg_wr_data[COUNT_W-1:0];
                    REG_WEIGHT_LIMIT: weight_limit_reg <= cfg_wr_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Result payload needs no reset
    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Broadcast control to the chain: push lands at the tail, pop advances every cell
    assign cell_ctrl.load  = in_xfer && push_ok;
    assign cell_ctrl.shift = in_xfer && pop_ok;
    assign cell_ctrl.fill  = held_count_reg;

    for (genvar i = 0; i < CELLS; i++) begin : g_cell
        if (i == CELLS - 1) begin : g_tail
            // Last cell has no neighbor; hold its own value on a shift
            wlf_cell #(.INDEX(i)) u_cell (
                .aclk           (aclk),
                .ctrl           (cell_ctrl),
                .push_entry     (in_entry),
                .neighbor_entry (cell_entry[i]),
                .entry          (cell_entry[i])
            );
        end else begin : g_body
            wlf_cell #(.INDEX(i)) u_cell (
                .aclk           (aclk),
                .ctrl           (cell_ctrl),
                .push_entry     (in_entry),
                .neighbor_entry (cell_entry[i+1]),
                .entry          (cell_entry[i])
            );
        end
    end

`include "assert_macros.svh"

    `ASSERT_ALWAYS(a_count_bound, aclk, aresetn, held_count_reg <= CELLS_L, "fill level beyond cell count")
    `ASSERT_NEXT(a_push_grows, aclk, aresetn, in_xfer && push_ok, held_count_reg == $past(held_count_reg) + COUNT_W'(1), "accepted push did not advance fill level")
    `ASSERT_NEXT(a_clear_empties, aclk, aresetn, in_xfer && (in_op == OP_CLEAR), (held_count_reg == '0) && (total_weight_reg == '0), "clear left entries or weight")
    `ASSERT_SAME(a_empty_result, aclk, aresetn, m_tvalid && (m_tdata[1:0] == ST_EMPTY), m_tdata[152:146] == '0, "empty status with nonzero count")

endmodule
